/* hdl/xrg_pkg.sv */
// Shared types and constants for the xorshift128 range generator.
// No dependencies; used by xrg_ctrl, xrg_dp and the top level.
`default_nettype none

package xrg_pkg;

	localparam int WIDTH = 32;
	localparam logic [31:0] WIDTH_MASK = 32'((64'd1 << WIDTH) - 64'd1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED = 1'b1;

	localparam logic [31:0] SEED_A = 32'd123456789;
	localparam logic [31:0] SEED_B = 32'd362436069;
	localparam logic [31:0] SEED_C = 32'd521288629;
	// rotl(SEED_A, 13) and rotl(SEED_B, 7)
	localparam logic [31:0] INIT_A = {SEED_A[18:0], SEED_A[31:19]};
	localparam logic [31:0] INIT_B = {SEED_B[24:0], SEED_B[31:25]};

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef enum logic [1:0] {
		RES_RAW,
		RES_EQ,
		RES_MOD
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     advance;
		logic     div_start;
		logic     div_step;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic raw;
		logic bounds_eq;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

/* hdl/xrg_ctrl.sv */
// Controller state machine for the xorshift128 range generator.
// Depends on xrg_pkg; drives commands into xrg_dp and owns the output valid flag.
`default_nettype none

module xrg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire xrg_pkg::sts_t sts,
	output xrg_pkg::cmd_t      cmd
);

	xrg_pkg::state_t state_q, state_nxt;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xrg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.res_sel   = xrg_pkg::RES_RAW;
		case (state_q)
			xrg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = xrg_pkg::ST_PREP;
				end
			end
			xrg_pkg::ST_PREP: begin
				if (sts.raw) begin
					cmd.advance  = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_sel  = xrg_pkg::RES_RAW;
					state_nxt    = xrg_pkg::ST_WRITE;
				end else if (sts.bounds_eq) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = xrg_pkg::RES_EQ;
					state_nxt    = xrg_pkg::ST_WRITE;
				end else begin
					cmd.advance   = 1'b1;
					cmd.div_start = 1'b1;
					state_nxt     = xrg_pkg::ST_DIV;
				end
			end
			xrg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = xrg_pkg::RES_MOD;
					state_nxt    = xrg_pkg::ST_WRITE;
				end
			end
			xrg_pkg::ST_WRITE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = xrg_pkg::ST_IDLE;
				end
			end
			default: state_nxt = xrg_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* hdl/xrg_dp.sv */
// Datapath for the xorshift128 range generator: generator words, config
// registers, bound sorting, restoring divider and output register. Uses xrg_pkg.
`default_nettype none

module xrg_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [xrg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	input  wire logic                          mode,
	input  wire logic [31:0]                   bound_a,
	input  wire logic [31:0]                   bound_b,
	input  wire xrg_pkg::cmd_t                 cmd,
	output xrg_pkg::sts_t                      sts,
	output logic [31:0]                        value
);

	logic        signed_q;
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic [31:0] t_mix, d_nxt;

	logic        mode_q;
	logic [31:0] ba_q, bb_q;
	logic [31:0] a_ext, b_ext;
	logic        a_gt_b;
	logic [31:0] hi, lo, span;

	logic [31:0]                    dvd_q, rem_q, span_q, lo_q;
	logic [xrg_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [32:0]                    trial, diff;
	logic [31:0]                    rem_nxt;

	logic [31:0] res_q, value_q;

	assign t_mix = wa_q ^ (wa_q << 11);
	assign d_nxt = (wd_q ^ (wd_q >> 19)) ^ (t_mix ^ (t_mix >> 8));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b1;
			wa_q     <= xrg_pkg::INIT_A;
			wb_q     <= xrg_pkg::INIT_B;
			wc_q     <= xrg_pkg::SEED_C;
			wd_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == xrg_pkg::REG_SIGNED)
				signed_q <= cfg_data[0];
			if (cfg_we && cfg_index == xrg_pkg::REG_SEED) begin
				wa_q <= xrg_pkg::INIT_A ^ cfg_data;
				wb_q <= xrg_pkg::INIT_B ^ cfg_data;
				wc_q <= xrg_pkg::SEED_C;
				wd_q <= cfg_data;
			end else if (cmd.advance) begin
				wa_q <= wb_q;
				wb_q <= wc_q;
				wc_q <= wd_q;
				wd_q <= d_nxt;
			end
		end
	end

	always_comb begin
		a_ext = ba_q & xrg_pkg::WIDTH_MASK;
		b_ext = bb_q & xrg_pkg::WIDTH_MASK;
		if (signed_q && a_ext[xrg_pkg::WIDTH-1])
			a_ext = a_ext | ~xrg_pkg::WIDTH_MASK;
		if (signed_q && b_ext[xrg_pkg::WIDTH-1])
			b_ext = b_ext | ~xrg_pkg::WIDTH_MASK;
		if (signed_q)
			a_gt_b = (a_ext ^ 32'h8000_0000) > (b_ext ^ 32'h8000_0000);
		else
			a_gt_b = a_ext > b_ext;
		hi   = a_gt_b ? a_ext : b_ext;
		lo   = a_gt_b ? b_ext : a_ext;
		span = hi - lo;
	end

	// restoring divider, one quotient bit per cycle; only the remainder is kept
	assign trial   = {rem_q, dvd_q[31]};
	assign diff    = trial - {1'b0, span_q};
	assign rem_nxt = diff[32] ? trial[31:0] : diff[31:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			ba_q   <= bound_a;
			bb_q   <= bound_b;
		end
		if (cmd.div_start) begin
			dvd_q  <= d_nxt;
			rem_q  <= '0;
			span_q <= span;
			lo_q   <= lo;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= rem_nxt;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				xrg_pkg::RES_RAW: res_q <= d_nxt;
				xrg_pkg::RES_EQ:  res_q <= a_ext;
				xrg_pkg::RES_MOD: res_q <= rem_nxt + lo_q;
				default:          res_q <= d_nxt;
			endcase
		end
		if (cmd.out_load)
			value_q <= res_q & xrg_pkg::WIDTH_MASK;
	end

	assign sts.raw       = !mode_q;
	assign sts.bounds_eq = (a_ext == b_ext);
	assign sts.div_last  = (cnt_q == xrg_pkg::DIV_LAST);
	assign value         = value_q;

endmodule

`default_nettype wire

/* hdl/xorshift128_range_generator.sv */
// Top level of the xorshift128 range generator.
// Instantiates xrg_ctrl and xrg_dp; uses xrg_pkg.
//
// Draws one value per input transfer. Mode 0 returns the next xorshift128
// word; mode 1 returns min + (word mod (max - min)) for the two bounds, or the
// first bound unchanged (without advancing) when the bounds are equal. A raw
// draw or an equal-bounds draw passes through the result register into the
// output register; a ranged draw first runs the 32 steps of the single
// one-bit-per-cycle restoring divider. One item is in work at a time; the
// output register lets the next item enter while a result waits. Writing the
// seed register (index 0) reloads the generator words; index 1 selects signed
// (1, reset) or unsigned bound comparison. Write registers only while idle.
`default_nettype none

module xorshift128_range_generator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [xrg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          mode,
	input  wire logic [31:0]                   bound_a,
	input  wire logic [31:0]                   bound_b,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [31:0]                        value
);

	xrg_pkg::cmd_t cmd;
	xrg_pkg::sts_t sts;

	xrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	xrg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.bound_a   (bound_a),
		.bound_b   (bound_b),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value)
	);

endmodule

`default_nettype wire

/* dv/xrg_tb_pkg.sv */
`timescale 1ns / 1ps
// Draw mode codes shared by the xorshift128 range generator testbench files.
// No dependencies; used by xrg_draw_checker and tb_xorshift128_range_generator.
package xrg_tb_pkg;

	localparam logic MODE_RAW   = 1'b0;
	localparam logic MODE_RANGE = 1'b1;

endpackage

/* dv/xrg_draw_checker.sv */
`timescale 1ns / 1ps
// Checker for the xorshift128 range generator: follows register writes, predicts each
// drawn value at input transfer and compares output transfers in order.
// Depends on xrg_pkg and xrg_tb_pkg.
module xrg_draw_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [xrg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          mode,
	input  logic [31:0]                   bound_a,
	input  logic [31:0]                   bound_b,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [31:0]                   value,
	output int                            mismatches,
	output int                            outstanding
);
	import xrg_pkg::*;
	import xrg_tb_pkg::*;

	localparam int REPORT_LIMIT = 40;

	logic [31:0] seed_word;
	logic        signed_cmp;
	logic [31:0] word_a, word_b, word_c, word_d;
	logic [31:0] expected_values[$];
	int          err_count;

	function automatic void load_words(input logic [31:0] s);
		word_a = INIT_A ^ s;
		word_b = INIT_B ^ s;
		word_c = SEED_C;
		word_d = s;
	endfunction

	function automatic logic [31:0] next_word();
		logic [31:0] t;
		t = word_a ^ (word_a << 11);
		word_a = word_b;
		word_b = word_c;
		word_c = word_d;
		word_d = word_d ^ (word_d >> 19) ^ t ^ (t >> 8);
		return word_d;
	endfunction

	function automatic logic [31:0] widen(input logic [31:0] v);
		logic [31:0] w;
		w = v & WIDTH_MASK;
		if (signed_cmp && w[WIDTH-1])
			w = w | ~WIDTH_MASK;
		return w;
	endfunction

	function automatic logic is_above(input logic [31:0] x, input logic [31:0] y);
		if (signed_cmp)
			return (x ^ 32'h8000_0000) > (y ^ 32'h8000_0000);
		return x > y;
	endfunction

	function automatic logic [31:0] predict_draw(input logic m, input logic [31:0] a,
			input logic [31:0] b);
		logic [31:0] ea, eb, hi, lo, r;
		if (m == MODE_RAW) begin
			r = next_word();
		end else begin
			ea = widen(a);
			eb = widen(b);
			if (ea == eb) begin
				r = ea;
			end else begin
				hi = is_above(ea, eb) ? ea : eb;
				lo = is_above(ea, eb) ? eb : ea;
				r = (next_word() % (hi - lo)) + lo;
			end
		end
		return r & WIDTH_MASK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] exp_value;
		if (!arst_n) begin
			seed_word = '0;
			signed_cmp = 1'b1;
			load_words(seed_word);
			expected_values.delete();
			err_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SEED: begin
						seed_word = cfg_data;
						load_words(seed_word);
					end
					REG_SIGNED: signed_cmp = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_values.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_LIMIT)
						$display("%0t: unexpected transfer, expected none, actual %08h",
							$time, value);
				end else begin
					exp_value = expected_values.pop_front();
					if (value !== exp_value) begin
						err_count++;
						if (err_count <= REPORT_LIMIT)
							$display("%0t: value mismatch, expected %08h, actual %08h",
								$time, exp_value, value);
					end
				end
			end
			if (in_valid && in_ready)
				expected_values.push_back(predict_draw(mode, bound_a, bound_b));
			mismatches <= err_count;
			outstanding <= expected_values.size();
		end
	end

endmodule

/* dv/tb_xorshift128_range_generator.sv */
`timescale 1ns / 1ps
// Top of the xorshift128 range generator testbench: clock, reset, register phases,
// directed and random draws with random idling on both channels, and the verdict.
// Depends on xrg_pkg, xrg_tb_pkg, xrg_draw_checker and the generator RTL.
module tb_xorshift128_range_generator;
	import xrg_tb_pkg::*;

	localparam int RESET_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASES         = 6;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [xrg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                   cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic                          mode;
	logic [31:0]                   bound_a;
	logic [31:0]                   bound_b;
	logic                          out_valid;
	logic                          out_ready;
	logic [31:0]                   value;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	bit hold_out_req;
	bit steady_send;

	xorshift128_range_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.bound_a   (bound_a),
		.bound_b   (bound_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

	xrg_draw_checker draw_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.bound_a     (bound_a),
		.bound_b     (bound_b),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [31:0] pick_corner();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'hFFFF_FFFE;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// valid stays high across back-to-back transfers; lowered only for a gap
	task automatic send_draw(input logic m, input logic [31:0] a, input logic [31:0] b);
		int gap;
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		bound_a <= a;
		bound_b <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_random_draw();
		logic [31:0] a, b, t;
		int r;
		a = $urandom();
		b = $urandom();
		r = $urandom_range(0, 99);
		if (r < 25) begin
			send_draw(MODE_RAW, a, b);
		end else begin
			case ($urandom_range(0, 9))
				0: b = a;
				1: begin
					a = pick_corner();
					b = pick_corner();
				end
				2, 3: begin
					b = a + $urandom_range(1, 16);
					if ($urandom_range(0, 1)) begin
						t = a;
						a = b;
						b = t;
					end
				end
				4: a = pick_corner();
				default: ;
			endcase
			send_draw(MODE_RANGE, a, b);
		end
	endtask

	task automatic run_directed();
		send_draw(MODE_RAW, 32'h0000_0000, 32'h0000_0000);
		send_draw(MODE_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draw(MODE_RANGE, 32'h0000_0005, 32'h0000_0005);
		send_draw(MODE_RANGE, 32'h0000_0000, 32'h0000_0000);
		send_draw(MODE_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draw(MODE_RANGE, 32'h0000_0000, 32'h0000_0001);
		send_draw(MODE_RANGE, 32'h0000_0001, 32'h0000_0000);
		send_draw(MODE_RANGE, 32'h0000_0000, 32'hFFFF_FFFF);
		send_draw(MODE_RANGE, 32'hFFFF_FFFF, 32'h0000_0000);
		send_draw(MODE_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
		send_draw(MODE_RANGE, 32'h0000_1000, 32'h0000_0010);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_regs(input logic [31:0] seed, input logic sgn);
		cfg_we <= 1'b1;
		cfg_index <= xrg_pkg::REG_SEED;
		cfg_data <= seed;
		@(posedge clk);
		cfg_index <= xrg_pkg::REG_SIGNED;
		cfg_data <= {31'd0, sgn};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= xrg_pkg::REG_SEED;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= MODE_RAW;
		bound_a <= '0;
		bound_b <= '0;
		hold_out_req <= 1'b0;
		steady_send = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: set_regs(32'hFFFF_FFFF, 1'b0);
				2: set_regs($urandom(), 1'b1);
				3: set_regs(32'h0000_0000, 1'b0);
				4: set_regs($urandom(), 1'b0);
				5: set_regs(32'h0000_0001, 1'b1);
				default: ;
			endcase
			steady_send = (p == 2);
			if (p < 2)
				run_directed();
			// output held off while draws keep coming
			if (p == 1)
				hold_out_req <= 1'b1;
			repeat ((p == 0) ? 130 : 140) send_random_draw();
			wait_drained();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		bit held;
		int r;
		held = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_out_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					out_ready <= 1'b1;
					repeat ($urandom_range(100, 200)) @(posedge clk);
				end else if (r < 60) begin
					out_ready <= 1'b1;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end else begin
					out_ready <= 1'b0;
					repeat (pick_gap() + 1) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

/* sim.f */
hdl/xrg_pkg.sv
hdl/xrg_ctrl.sv
hdl/xrg_dp.sv
hdl/xorshift128_range_generator.sv
dv/xrg_tb_pkg.sv
dv/xrg_draw_checker.sv
dv/tb_xorshift128_range_generator.sv
